FILE: sv/lbmp_pkg.sv
package lbmp_pkg;

    localparam int PRIME_BITS_DEF = 17;
    localparam int VALUE_BITS_DEF = 64;
    localparam int APB_DATA_BITS  = 32;
    localparam int APB_ADDR_BITS  = 3;
    localparam int PRIME_RESET    = 2;

    // register index, taken from paddr[2]
    localparam logic REG_PRIME = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_LOOP,
        S_MUL_NUM,
        S_MUL_DEN,
        S_POW,
        S_MUL_PACC,
        S_MUL_BASE,
        S_MUL_FIN,
        S_MUL_ACC,
        S_OUT
    } t_state;

endpackage

FILE: sv/lbmp_if.sv
interface lbmp_in_if #(
    parameter int VALUE_BITS = lbmp_pkg::VALUE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] n_value;
    logic [VALUE_BITS-1:0] k_value;

    modport source (output valid, output n_value, output k_value, input ready);
    modport sink   (input valid, input n_value, input k_value, output ready);
endinterface

interface lbmp_out_if #(
    parameter int PRIME_BITS = lbmp_pkg::PRIME_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [PRIME_BITS-1:0] binomial_mod;

    modport source (output valid, output binomial_mod, input ready);
    modport sink   (input valid, input binomial_mod, output ready);
endinterface

FILE: sv/lbmp_div.sv
module lbmp_div #(
    parameter int PRIME_BITS = lbmp_pkg::PRIME_BITS_DEF,
    parameter int VALUE_BITS = lbmp_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_dividend,
    input  logic [PRIME_BITS-1:0] i_divisor,
    output logic [VALUE_BITS-1:0] o_quot,
    output logic [PRIME_BITS-1:0] o_rem,
    output logic                  o_done
);
    import lbmp_pkg::*;

    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] r_q, n_q;
    logic [PRIME_BITS-1:0] r_rem, n_rem;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [PRIME_BITS:0]   w_trial;
    logic [PRIME_BITS:0]   w_sub;
    logic                  w_bit;

    // restoring division, one quotient bit a cycle from the top
    always_comb begin
        w_trial = {r_rem, r_q[VALUE_BITS-1]};
        w_bit   = (w_trial >= {1'b0, i_divisor});
        w_sub   = w_bit ? (w_trial - {1'b0, i_divisor}) : w_trial;
    end

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_q    = i_dividend;
            n_rem  = '0;
            n_cnt  = CNT_BITS'(VALUE_BITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_q   = {r_q[VALUE_BITS-2:0], w_bit};
            n_rem = w_sub[PRIME_BITS-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
    end

    assign o_quot = r_q;
    assign o_rem  = r_rem;
    assign o_done = r_done;
endmodule

FILE: sv/lbmp_mulmod.sv
module lbmp_mulmod #(
    parameter int PRIME_BITS = lbmp_pkg::PRIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [PRIME_BITS-1:0] i_a,
    input  logic [PRIME_BITS-1:0] i_b,
    input  logic [PRIME_BITS-1:0] i_prime,
    output logic [PRIME_BITS-1:0] o_result,
    output logic                  o_done
);
    import lbmp_pkg::*;

    localparam int CNT_BITS = $clog2(PRIME_BITS + 1);

    logic [PRIME_BITS-1:0] r_acc, n_acc;
    logic [PRIME_BITS-1:0] r_a, n_a;
    logic [PRIME_BITS-1:0] r_b, n_b;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [PRIME_BITS:0]   w_dbl, w_dbl_red, w_add, w_add_red, w_p;

    // interleaved shift-add, b taken msb first, both operands below p
    always_comb begin
        w_p       = {1'b0, i_prime};
        w_dbl     = {r_acc, 1'b0};
        w_dbl_red = (w_dbl >= w_p) ? (w_dbl - w_p) : w_dbl;
        w_add     = r_b[PRIME_BITS-1] ? (w_dbl_red + {1'b0, r_a}) : w_dbl_red;
        w_add_red = (w_add >= w_p) ? (w_add - w_p) : w_add;
    end

    always_comb begin
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_acc  = '0;
            n_a    = i_a;
            n_b    = i_b;
            n_cnt  = CNT_BITS'(PRIME_BITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_acc = w_add_red[PRIME_BITS-1:0];
            n_b   = {r_b[PRIME_BITS-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    assign o_result = r_acc;
    assign o_done   = r_done;
endmodule

FILE: sv/lucas_binomial_mod_prime_unit.sv
// binomial coefficient C(n,k) mod p by lucas's theorem
// i_in carries n_value and k_value, o_out carries binomial_mod; a transfer
// happens on a clock edge with valid and ready both high
// p is set through the apb port (register 0 at byte address 0); the user
// must write it only while idle, the block does not enforce this; only the
// low PRIME_BITS bits of pwdata are kept and a read returns p; one item is
// worked at a time: i_in.ready is high only while idle
// per base-p digit the block runs the serial divider (n and k are
// divided side by side), then the falling products with j = min(k_i,
// n_i-k_i), then the fermat inverse; every modular multiply goes one
// bit a cycle through the single shared multiplier
// the walk stops once k runs out of digits or the product reaches zero;
// with p below two no digit is worked and the result is zero, and with
// k zero the result is one
// the result sits in its register with o_out.valid high until taken; a
// stalled receiver simply holds the block in that state
// reset returns p to 2 and drops any item in flight
module lucas_binomial_mod_prime_unit #(
    parameter int PRIME_BITS = lbmp_pkg::PRIME_BITS_DEF,
    parameter int VALUE_BITS = lbmp_pkg::VALUE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    lbmp_in_if.sink                             i_in,
    lbmp_out_if.source                          o_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lbmp_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [lbmp_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [lbmp_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);
    import lbmp_pkg::*;

    t_state r_state, n_state;

    logic [PRIME_BITS-1:0] r_prime;
    logic [VALUE_BITS-1:0] r_n, n_n;
    logic [VALUE_BITS-1:0] r_k, n_k;
    logic [PRIME_BITS-1:0] r_acc, n_acc;
    logic [PRIME_BITS-1:0] r_top, n_top;
    logic [PRIME_BITS-1:0] r_j, n_j;
    logic [PRIME_BITS-1:0] r_i, n_i;
    logic [PRIME_BITS-1:0] r_num, n_num;
    logic [PRIME_BITS-1:0] r_den, n_den;
    logic [PRIME_BITS-1:0] r_base, n_base;
    logic [PRIME_BITS-1:0] r_pacc, n_pacc;
    logic [PRIME_BITS-1:0] r_expo, n_expo;
    logic                  r_issued, n_issued;

    logic                  w_in_xfer, w_out_xfer, w_cfg_wr;
    logic                  w_div_start, w_n_done, w_k_done;
    logic [VALUE_BITS-1:0] w_n_quot, w_k_quot;
    logic [PRIME_BITS-1:0] w_n_rem, w_k_rem, w_diff;
    logic                  w_mul_state, w_mul_start, w_mul_done;
    logic [PRIME_BITS-1:0] w_mul_a, w_mul_b, w_mul_res;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PRIME);
    assign prdata   = (paddr[2] == REG_PRIME) ? APB_DATA_BITS'(r_prime) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prime <= PRIME_BITS'(PRIME_RESET);
        end else if (w_cfg_wr) begin
            r_prime <= pwdata[PRIME_BITS-1:0];
        end
    end

    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_xfer = o_out.valid && o_out.ready;

    lbmp_div #(.PRIME_BITS(PRIME_BITS), .VALUE_BITS(VALUE_BITS)) u_div_n (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_n),
        .i_divisor  (r_prime),
        .o_quot     (w_n_quot),
        .o_rem      (w_n_rem),
        .o_done     (w_n_done)
    );

    lbmp_div #(.PRIME_BITS(PRIME_BITS), .VALUE_BITS(VALUE_BITS)) u_div_k (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_k),
        .i_divisor  (r_prime),
        .o_quot     (w_k_quot),
        .o_rem      (w_k_rem),
        .o_done     (w_k_done)
    );

    lbmp_mulmod #(.PRIME_BITS(PRIME_BITS)) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_a      (w_mul_a),
        .i_b      (w_mul_b),
        .i_prime  (r_prime),
        .o_result (w_mul_res),
        .o_done   (w_mul_done)
    );

    // multiplier operands by state
    always_comb begin
        w_mul_a = r_acc;
        w_mul_b = r_num;
        case (r_state)
            S_MUL_NUM: begin
                w_mul_a = r_num;
                w_mul_b = r_top - r_i;
            end
            S_MUL_DEN: begin
                w_mul_a = r_den;
                w_mul_b = r_j - r_i;
            end
            S_MUL_PACC: begin
                w_mul_a = r_pacc;
                w_mul_b = r_base;
            end
            S_MUL_BASE: begin
                w_mul_a = r_base;
                w_mul_b = r_base;
            end
            S_MUL_FIN: begin
                w_mul_a = r_num;
                w_mul_b = r_pacc;
            end
            default: begin
                w_mul_a = r_acc;
                w_mul_b = r_num;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = (r_prime < PRIME_BITS'(2)) ? S_OUT : S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = ((r_k == '0) || (r_acc == '0)) ? S_OUT : S_DIV;
            end
            S_DIV: begin
                if (w_n_done && w_k_done) begin
                    n_state = ((w_k_rem >= w_n_rem)) ? S_CHECK : S_LOOP;
                end
            end
            S_LOOP:     n_state = (r_i == r_j) ? S_POW : S_MUL_NUM;
            S_MUL_NUM:  if (w_mul_done) n_state = S_MUL_DEN;
            S_MUL_DEN:  if (w_mul_done) n_state = S_LOOP;
            S_POW: begin
                if (r_expo == '0) begin
                    n_state = S_MUL_FIN;
                end else if (r_expo[0]) begin
                    n_state = S_MUL_PACC;
                end else begin
                    n_state = S_MUL_BASE;
                end
            end
            S_MUL_PACC: if (w_mul_done) n_state = S_MUL_BASE;
            S_MUL_BASE: if (w_mul_done) n_state = S_POW;
            S_MUL_FIN:  if (w_mul_done) n_state = S_MUL_ACC;
            S_MUL_ACC:  if (w_mul_done) n_state = S_CHECK;
            S_OUT:      if (w_out_xfer) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // handshake and unit strobes
    always_comb begin
        i_in.ready  = 1'b0;
        o_out.valid = 1'b0;
        w_div_start = 1'b0;
        w_mul_state = 1'b0;
        case (r_state)
            S_IDLE:  i_in.ready  = 1'b1;
            S_OUT:   o_out.valid = 1'b1;
            S_CHECK: w_div_start = (r_k != '0) && (r_acc != '0);
            S_MUL_NUM, S_MUL_DEN, S_MUL_PACC, S_MUL_BASE, S_MUL_FIN, S_MUL_ACC: begin
                w_mul_state = 1'b1;
            end
            default: begin
                i_in.ready  = 1'b0;
                o_out.valid = 1'b0;
            end
        endcase
    end

    assign w_mul_start        = w_mul_state && !r_issued;
    assign o_out.binomial_mod = r_acc;
    assign w_diff             = w_n_rem - w_k_rem;

    // datapath
    always_comb begin
        n_n      = r_n;
        n_k      = r_k;
        n_acc    = r_acc;
        n_top    = r_top;
        n_j      = r_j;
        n_i      = r_i;
        n_num    = r_num;
        n_den    = r_den;
        n_base   = r_base;
        n_pacc   = r_pacc;
        n_expo   = r_expo;
        n_issued = r_issued;
        if (w_mul_start) begin
            n_issued = 1'b1;
        end
        if (w_mul_done) begin
            n_issued = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                n_n   = i_in.n_value;
                n_k   = i_in.k_value;
                n_acc = (r_prime < PRIME_BITS'(2)) ? '0 : PRIME_BITS'(1);
            end
            S_DIV: begin
                if (w_n_done && w_k_done) begin
                    n_n   = w_n_quot;
                    n_k   = w_k_quot;
                    n_top = w_n_rem;
                    n_j   = (w_k_rem > w_diff) ? w_diff : w_k_rem;
                    n_i   = '0;
                    n_num = PRIME_BITS'(1);
                    n_den = PRIME_BITS'(1);
                    // digit of k above digit of n kills the product
                    if (w_k_rem > w_n_rem) begin
                        n_acc = '0;
                    end
                end
            end
            S_LOOP: begin
                if (r_i == r_j) begin
                    n_base = r_den;
                    n_expo = r_prime - PRIME_BITS'(2);
                    n_pacc = PRIME_BITS'(1);
                end
            end
            S_MUL_NUM:  if (w_mul_done) n_num = w_mul_res;
            S_MUL_DEN: begin
                if (w_mul_done) begin
                    n_den = w_mul_res;
                    n_i   = r_i + 1'b1;
                end
            end
            S_MUL_PACC: if (w_mul_done) n_pacc = w_mul_res;
            S_MUL_BASE: begin
                if (w_mul_done) begin
                    n_base = w_mul_res;
                    n_expo = r_expo >> 1;
                end
            end
            S_MUL_FIN:  if (w_mul_done) n_num = w_mul_res;
            S_MUL_ACC:  if (w_mul_done) n_acc = w_mul_res;
            default: begin
                n_acc = r_acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
        end
        r_n    <= n_n;
        r_k    <= n_k;
        r_acc  <= n_acc;
        r_top  <= n_top;
        r_j    <= n_j;
        r_i    <= n_i;
        r_num  <= n_num;
        r_den  <= n_den;
        r_base <= n_base;
        r_pacc <= n_pacc;
        r_expo <= n_expo;
    end
endmodule

FILE: sv/lbmp_chk.sv
module lbmp_chk #(
    parameter int PRIME_BITS = lbmp_pkg::PRIME_BITS_DEF
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic [PRIME_BITS-1:0]               i_out_value,
    input logic [lbmp_pkg::APB_ADDR_BITS-1:0]  i_paddr,
    input logic [lbmp_pkg::APB_DATA_BITS-1:0]  i_prdata
);
    import lbmp_pkg::*;

    logic [APB_DATA_BITS-1:0] w_val;
    assign w_val = APB_DATA_BITS'(i_out_value);

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("result or busy state survived reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input taken while a result waits");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after a transfer");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_paddr[2] == REG_PRIME) |->
            (w_val < i_prdata) || (w_val == '0))
        else $error("result not reduced below the prime");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value))
        else $error("stalled result changed");
endmodule

bind lucas_binomial_mod_prime_unit lbmp_chk #(.PRIME_BITS(PRIME_BITS)) u_lbmp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.binomial_mod),
    .i_paddr     (paddr),
    .i_prdata    (prdata)
);
